FILE: hw/rtl/phoh_pkg.sv
// Shared types, constants and tables of the phi occupancy histogram.
`default_nettype none
package phoh_pkg;

  // Default sizes of the histogram store
  localparam int NUM_HISTOGRAMS_DEF = 64;
  localparam int NUM_BINS_DEF       = 100;
  localparam int COUNT_WIDTH_DEF    = 32;

  // Hit decoding
  localparam int MODULE_LSB = 12;
  localparam int MODULE_W   = 6;

  // CORDIC: coordinates scaled by 256, angle in Q16 radians
  localparam int CORDIC_ITERS = 16;
  localparam int ITER_W       = 4;
  localparam int XY_W         = 32;
  localparam int Z_W          = 20;
  localparam logic signed [Z_W-1:0] HALF_PI_Q16 = 20'sd102944;

  // Binning: bin = (phi*100 + 315*2^16) * NUM_BINS / (630*2^16), taken as a
  // shift by 16 and a multiply by ceil(2^30/630), exact for dividends below 2^20
  localparam int NUM_W      = 28;
  localparam int PROD_W     = 36;
  localparam int SPAN_SHIFT = 16;
  localparam int RECIP_W    = 21;
  localparam int RECIP_SH   = 30;
  localparam int QUO_W      = 11;
  localparam logic signed [NUM_W-1:0] RANGE_LO  = 28'sd20643840;
  localparam logic [RECIP_W-1:0]      RECIP_630 = 21'd1704353;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_MIN_MODULE          = 3'd0,
    CFG_MAX_MODULE          = 3'd1,
    CFG_MODULE_STEP         = 3'd2,
    CFG_RUN_FILTER_ENABLE   = 3'd3,
    CFG_RUN_SELECT          = 3'd4,
    CFG_EVENT_FILTER_ENABLE = 3'd5,
    CFG_EVENT_SELECT        = 3'd6
  } cfg_idx_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CORDIC,
    ST_SCALE,
    ST_MULT,
    ST_DIV,
    ST_ADDR,
    ST_READ,
    ST_UPDATE
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic clr_en;
    logic load;
    logic cordic_step;
    logic scale;
    logic mult;
    logic div_step;
    logic addr_calc;
    logic mem_rd;
    logic finish;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic clr_last;
    logic cordic_last;
    logic out_busy;
  } status_t;

  // Arctangent of 2^-i in Q16, rounded to nearest
  function automatic logic signed [Z_W-1:0] atan_q16(input logic [ITER_W-1:0] i);
    logic signed [Z_W-1:0] a;
    unique case (i)
      4'd0:    a = 20'sd51472;
      4'd1:    a = 20'sd30385;
      4'd2:    a = 20'sd16055;
      4'd3:    a = 20'sd8150;
      4'd4:    a = 20'sd4091;
      4'd5:    a = 20'sd2047;
      4'd6:    a = 20'sd1024;
      4'd7:    a = 20'sd512;
      4'd8:    a = 20'sd256;
      4'd9:    a = 20'sd128;
      4'd10:   a = 20'sd64;
      4'd11:   a = 20'sd32;
      4'd12:   a = 20'sd16;
      4'd13:   a = 20'sd8;
      4'd14:   a = 20'sd4;
      default: a = 20'sd2;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/module_phi_occupancy_histogram_top.sv
// Top level of the azimuthal occupancy histogram.
`default_nettype none
// Each hit beat is filtered on run, event and module range, mapped to histogram
// (module - min_module) / module_step, and given a phi bin from a bit-serial
// 16-step CORDIC followed by a reciprocal-multiply binning over [-3.15, 3.15).
// The bin's saturating counter is incremented in a single-port store and the
// new count returned. One item is in flight at a time: a hit passes through
// the accept cycle, 16 CORDIC steps, then scaling, the bin multiply, the bin
// divide, addressing, store read and update, a read beat through accept, store
// read and update; the update cycle waits while a previous result is still
// stalled. The result sits in an output register, so the next beat is taken
// while it waits. After reset the store is cleared by a sweep over all
// NUM_HISTOGRAMS*NUM_BINS entries (6400 by default) during which in_stall is
// high; configuration writes are taken at any time.
module module_phi_occupancy_histogram_top #(
  parameter int NUM_HISTOGRAMS = phoh_pkg::NUM_HISTOGRAMS_DEF,
  parameter int NUM_BINS       = phoh_pkg::NUM_BINS_DEF,
  parameter int COUNT_WIDTH    = phoh_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_kind,
  input  wire logic [31:0]        in_run_number,
  input  wire logic [31:0]        in_event_number,
  input  wire logic [31:0]        in_channel_id,
  input  wire logic signed [19:0] in_pos_x,
  input  wire logic signed [19:0] in_pos_y,
  input  wire logic [5:0]         in_read_histogram,
  input  wire logic [6:0]         in_read_bin,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_hit_accepted,
  output logic [5:0]              out_histogram_index,
  output logic [6:0]              out_phi_bin,
  output logic [31:0]             out_bin_count,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);
  import phoh_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  assign in_stall = !in_ready;

  phoh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  phoh_dp #(
    .NUM_HISTOGRAMS (NUM_HISTOGRAMS),
    .NUM_BINS       (NUM_BINS),
    .COUNT_WIDTH    (COUNT_WIDTH)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .status              (status),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_kind             (in_kind),
    .in_run_number       (in_run_number),
    .in_event_number     (in_event_number),
    .in_channel_id       (in_channel_id),
    .in_pos_x            (in_pos_x),
    .in_pos_y            (in_pos_y),
    .in_read_histogram   (in_read_histogram),
    .in_read_bin         (in_read_bin),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_hit_accepted    (out_hit_accepted),
    .out_histogram_index (out_histogram_index),
    .out_phi_bin         (out_phi_bin),
    .out_bin_count       (out_bin_count)
  );

endmodule
`default_nettype wire

FILE: hw/rtl/phoh_cordic.sv
// Bit-serial vectoring CORDIC giving atan2(y, x) in Q16 radians.
`default_nettype none
module phoh_cordic (
  input  wire logic                           clk,
  input  wire logic                           load,
  input  wire logic                           step,
  input  wire logic [phoh_pkg::ITER_W-1:0]    shift,
  input  wire logic signed [19:0]             pos_x,
  input  wire logic signed [19:0]             pos_y,
  output logic signed [phoh_pkg::Z_W-1:0]     phi
);
  import phoh_pkg::*;

  logic signed [XY_W-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [Z_W-1:0]  z_r, z_nxt;
  logic                   origin_r, origin_nxt;
  logic signed [XY_W-1:0] xs, ys, xl, yl;

  // Pre-rotate into the right half plane on load, then rotate once per step
  always_comb begin
    xl = XY_W'(pos_x) <<< 8;
    yl = XY_W'(pos_y) <<< 8;
    xs = x_r >>> shift;
    ys = y_r >>> shift;
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    origin_nxt = origin_r;
    if (load) begin
      origin_nxt = (pos_x == 20'sd0) && (pos_y == 20'sd0);
      if (xl < 0) begin
        if (yl >= 0) begin
          x_nxt = yl;
          y_nxt = -xl;
          z_nxt = HALF_PI_Q16;
        end else begin
          x_nxt = -yl;
          y_nxt = xl;
          z_nxt = -HALF_PI_Q16;
        end
      end else begin
        x_nxt = xl;
        y_nxt = yl;
        z_nxt = '0;
      end
    end else if (step) begin
      if (y_r > 0) begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + atan_q16(shift);
      end else begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - atan_q16(shift);
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    z_r      <= z_nxt;
    origin_r <= origin_nxt;
  end

  // Origin hit reads as zero angle
  assign phi = origin_r ? '0 : z_r;

endmodule
`default_nettype wire

FILE: hw/rtl/phoh_dp.sv
// Datapath: configuration, filters, index divider, binning, count store and output register.
`default_nettype none
module phoh_dp #(
  parameter int NUM_HISTOGRAMS = phoh_pkg::NUM_HISTOGRAMS_DEF,
  parameter int NUM_BINS       = phoh_pkg::NUM_BINS_DEF,
  parameter int COUNT_WIDTH    = phoh_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire phoh_pkg::cmd_t         cmd,
  output phoh_pkg::status_t           status,
  input  wire logic                   cfg_we,
  input  wire logic [2:0]             cfg_index,
  input  wire logic [31:0]            cfg_data,
  input  wire logic                   in_kind,
  input  wire logic [31:0]            in_run_number,
  input  wire logic [31:0]            in_event_number,
  input  wire logic [31:0]            in_channel_id,
  input  wire logic signed [19:0]     in_pos_x,
  input  wire logic signed [19:0]     in_pos_y,
  input  wire logic [5:0]             in_read_histogram,
  input  wire logic [6:0]             in_read_bin,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic                        out_hit_accepted,
  output logic [5:0]                  out_histogram_index,
  output logic [6:0]                  out_phi_bin,
  output logic [31:0]                 out_bin_count
);
  import phoh_pkg::*;

  localparam int DEPTH  = NUM_HISTOGRAMS * NUM_BINS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int BIN_W  = $clog2(NUM_BINS);
  localparam int SPAN_W = PROD_W - SPAN_SHIFT;
  localparam int RP_W   = SPAN_W + RECIP_W;

  // Configuration registers
  logic [MODULE_W-1:0] min_module_r, max_module_r, module_step_r;
  logic                run_en_r, event_en_r;
  logic [31:0]         run_sel_r, event_sel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_module_r  <= '0;
      max_module_r  <= 6'd63;
      module_step_r <= 6'd2;
      run_en_r      <= 1'b0;
      run_sel_r     <= '0;
      event_en_r    <= 1'b0;
      event_sel_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MIN_MODULE:          min_module_r  <= cfg_data[MODULE_W-1:0];
        CFG_MAX_MODULE:          max_module_r  <= cfg_data[MODULE_W-1:0];
        CFG_MODULE_STEP:         module_step_r <= cfg_data[MODULE_W-1:0];
        CFG_RUN_FILTER_ENABLE:   run_en_r      <= cfg_data[0];
        CFG_RUN_SELECT:          run_sel_r     <= cfg_data;
        CFG_EVENT_FILTER_ENABLE: event_en_r    <= cfg_data[0];
        CFG_EVENT_SELECT:        event_sel_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clear sweep counter
  logic [ADDR_W-1:0] clr_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clr_en) begin
      clr_r <= clr_r + 1'b1;
    end
  end
  assign status.clr_last = (clr_r == ADDR_W'(DEPTH - 1));

  // CORDIC iteration counter
  logic [ITER_W-1:0] iter_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iter_r <= '0;
    end else if (cmd.load) begin
      iter_r <= '0;
    end else if (cmd.cordic_step) begin
      iter_r <= iter_r + 1'b1;
    end
  end
  assign status.cordic_last = (iter_r == ITER_W'(CORDIC_ITERS - 1));

  // Filters and module range, decided on load
  logic [MODULE_W-1:0] mod;
  logic                drop_in;
  assign mod = in_channel_id[MODULE_LSB +: MODULE_W];
  assign drop_in = (run_en_r && (in_run_number != run_sel_r)) ||
                   (event_en_r && (in_event_number != event_sel_r)) ||
                   (mod < min_module_r) || (mod > max_module_r);

  logic                kind_r, drop_r, rd_ok_r;
  logic [5:0]          rh_r;
  logic [6:0]          rb_r;
  logic [ADDR_W-1:0]   addr_r;
  logic [BIN_W-1:0]    bin_r;

  // Histogram index divider: one quotient bit per step over the first CORDIC steps
  logic [MODULE_W-1:0] hdvd_r, hrem_r, hstep_r;
  logic [MODULE_W:0]   hshift;
  logic                hbit;
  assign hshift = {hrem_r, hdvd_r[MODULE_W-1]};
  assign hbit   = (hshift >= {1'b0, hstep_r});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hdvd_r  <= mod - min_module_r;
      hrem_r  <= '0;
      hstep_r <= (module_step_r == '0) ? 6'd1 : module_step_r;
    end else if (cmd.cordic_step && (iter_r < ITER_W'(MODULE_W))) begin
      hdvd_r <= {hdvd_r[MODULE_W-2:0], hbit};
      hrem_r <= hbit ? MODULE_W'(hshift - {1'b0, hstep_r}) : hshift[MODULE_W-1:0];
    end
  end

  // Angle unit
  logic signed [Z_W-1:0] phi;
  phoh_cordic u_cordic (
    .clk   (clk),
    .load  (cmd.load),
    .step  (cmd.cordic_step),
    .shift (iter_r),
    .pos_x (in_pos_x),
    .pos_y (in_pos_y),
    .phi   (phi)
  );

  // Binning: scale, multiply by bin count, then divide by the span as a
  // shift by 16 and a reciprocal multiply for the factor 630
  logic signed [NUM_W-1:0] num_r;
  logic [PROD_W-1:0]       prod_r;
  logic [RP_W-1:0]         recip_prod;
  logic [QUO_W-1:0]        quo_r;
  logic [BIN_W-1:0]        bin_c;

  assign recip_prod = RP_W'(prod_r[PROD_W-1:SPAN_SHIFT]) * RP_W'(RECIP_630);

  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      num_r <= NUM_W'(phi) * 28'sd100 + RANGE_LO;
    end
    if (cmd.mult) begin
      prod_r <= num_r[NUM_W-1] ? '0 : PROD_W'(num_r[NUM_W-2:0]) * PROD_W'(NUM_BINS);
    end
    if (cmd.div_step) begin
      quo_r <= recip_prod[RECIP_SH +: QUO_W];
    end
  end

  // Clamp the bin to the top of the range
  assign bin_c = (quo_r >= QUO_W'(NUM_BINS)) ? BIN_W'(NUM_BINS - 1) : BIN_W'(quo_r);

  // Item registers and store address
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r  <= in_kind;
      drop_r  <= drop_in;
      rh_r    <= in_read_histogram;
      rb_r    <= in_read_bin;
      rd_ok_r <= ({1'b0, in_read_histogram} < 7'(NUM_HISTOGRAMS)) &&
                 (9'(in_read_bin) < 9'(NUM_BINS));
      addr_r  <= ADDR_W'(in_read_histogram) * ADDR_W'(NUM_BINS) + ADDR_W'(in_read_bin);
    end else if (cmd.addr_calc) begin
      bin_r  <= bin_c;
      addr_r <= ADDR_W'(hdvd_r) * ADDR_W'(NUM_BINS) + ADDR_W'(bin_c);
    end
  end

  // Count store
  logic [COUNT_WIDTH-1:0] mem [DEPTH];
  logic [COUNT_WIDTH-1:0] rd_data_r, cnt_inc;
  logic                   hit_ok, wr_en;

  assign hit_ok  = !kind_r && !drop_r && ({1'b0, hdvd_r} < 7'(NUM_HISTOGRAMS));
  assign wr_en   = cmd.finish && hit_ok;
  assign cnt_inc = (&rd_data_r) ? rd_data_r : rd_data_r + 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.clr_en) begin
      mem[clr_r] <= '0;
    end else if (wr_en) begin
      mem[addr_r] <= cnt_inc;
    end
    if (cmd.mem_rd) begin
      rd_data_r <= mem[addr_r];
    end
  end

  // Output register
  logic        out_valid_r;
  logic        hit_r;
  logic [5:0]  hidx_r;
  logic [6:0]  obin_r;
  logic [31:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (kind_r) begin
        hit_r   <= 1'b0;
        hidx_r  <= rh_r;
        obin_r  <= rb_r;
        count_r <= rd_ok_r ? 32'(rd_data_r) : '0;
      end else if (hit_ok) begin
        hit_r   <= 1'b1;
        hidx_r  <= hdvd_r;
        obin_r  <= 7'(bin_r);
        count_r <= 32'(cnt_inc);
      end else begin
        hit_r   <= 1'b0;
        hidx_r  <= '0;
        obin_r  <= '0;
        count_r <= '0;
      end
    end
  end

  assign status.out_busy     = out_valid_r && out_stall;
  assign out_valid           = out_valid_r;
  assign out_hit_accepted    = hit_r;
  assign out_histogram_index = hidx_r;
  assign out_phi_bin         = obin_r;
  assign out_bin_count       = count_r;

endmodule
`default_nettype wire

FILE: hw/rtl/phoh_ctrl.sv
// Controller state machine sequencing clear, angle, binning and store update.
`default_nettype none
module phoh_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_kind,
  output logic                    in_ready,
  input  wire phoh_pkg::status_t  status,
  output phoh_pkg::cmd_t          cmd
);
  import phoh_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:  if (status.clr_last) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_valid) state_nxt = in_kind ? ST_READ : ST_CORDIC;
      end
      ST_CORDIC: if (status.cordic_last) state_nxt = ST_SCALE;
      ST_SCALE:  state_nxt = ST_MULT;
      ST_MULT:   state_nxt = ST_DIV;
      ST_DIV:    state_nxt = ST_ADDR;
      ST_ADDR:   state_nxt = ST_READ;
      ST_READ:   state_nxt = ST_UPDATE;
      ST_UPDATE: if (!status.out_busy) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_CLEAR:  cmd.clr_en = 1'b1;
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_CORDIC: cmd.cordic_step = 1'b1;
      ST_SCALE:  cmd.scale       = 1'b1;
      ST_MULT:   cmd.mult        = 1'b1;
      ST_DIV:    cmd.div_step    = 1'b1;
      ST_ADDR:   cmd.addr_calc   = 1'b1;
      ST_READ:   cmd.mem_rd      = 1'b1;
      ST_UPDATE: cmd.finish      = !status.out_busy;
      default: ;
    endcase
  end

endmodule
`default_nettype wire
